// ===== design/tacho_thermo_seven_segment_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tachometer and thermometer display block.
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TACHO_THERMO_SEVEN_SEGMENT_ASSERT_SVH
`define TACHO_THERMO_SEVEN_SEGMENT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTSS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TTSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ttss_pkg.sv =====
// ----------------------------------------------------------------------------
// ttss_pkg
// Shared types, constants and glyph tables of the tachometer display block.
// ----------------------------------------------------------------------------
`default_nettype none

package ttss_pkg;

  // Default number of periods averaged per speed reading.
  localparam int unsigned AvgCountDefault = 64;

  localparam int unsigned SampleW = 7;
  localparam int unsigned SumW    = 38;
  localparam int unsigned DvdW    = 32;
  localparam int unsigned AluW    = SumW + 1;
  localparam int unsigned ValW    = 16;
  localparam int unsigned CntW    = 5;
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned DigSteps = 15;
  localparam int unsigned RpmScale = 60000000;

  // Named glyph indexes: zero, the degree sign and blank.
  localparam logic [3:0] GlyphZero   = 4'd0;
  localparam logic [3:0] GlyphDegree = 4'd10;
  localparam logic [3:0] GlyphBlank  = 4'd11;

  typedef struct packed {
    logic        mode;
    logic [31:0] period_us;
    logic [15:0] temp_raw;
  } ttss_in_t;

  typedef struct packed {
    logic [6:0]  seg_thousands;
    logic [6:0]  seg_hundreds;
    logic [6:0]  seg_tens;
    logic [6:0]  seg_last;
    logic [15:0] shown_number;
    logic        value_updated;
  } ttss_out_t;

  // Sequencer status handed to the datapath.
  typedef struct packed {
    logic            idle;
    logic            div;
    logic            dig;
    logic            emit;
    logic            last;
    logic [CntW-1:0] cnt;
  } ttss_ctrl_t;

  // Active-low segments a..g at bits 6..0.
  function automatic logic [6:0] seg_glyph(logic [3:0] idx);
    logic [6:0] g;
    case (idx)
      4'd0:        g = 7'h01;
      4'd1:        g = 7'h4F;
      4'd2:        g = 7'h12;
      4'd3:        g = 7'h06;
      4'd4:        g = 7'h4C;
      4'd5:        g = 7'h24;
      4'd6:        g = 7'h20;
      4'd7:        g = 7'h0F;
      4'd8:        g = 7'h00;
      4'd9:        g = 7'h04;
      GlyphDegree: g = 7'h1C;
      default:     g = 7'h7F;
    endcase
    return g;
  endfunction

  // Scaled decimal weights for the digit split: thousands at steps 14..8,
  // hundreds at steps 7..4 and tens at steps 3..0.
  function automatic logic [ValW-1:0] dig_divisor(logic [CntW-1:0] cnt);
    logic [ValW-1:0] d;
    case (cnt)
      5'd14:   d = 16'd64000;
      5'd13:   d = 16'd32000;
      5'd12:   d = 16'd16000;
      5'd11:   d = 16'd8000;
      5'd10:   d = 16'd4000;
      5'd9:    d = 16'd2000;
      5'd8:    d = 16'd1000;
      5'd7:    d = 16'd800;
      5'd6:    d = 16'd400;
      5'd5:    d = 16'd200;
      5'd4:    d = 16'd100;
      5'd3:    d = 16'd80;
      5'd2:    d = 16'd40;
      5'd1:    d = 16'd20;
      5'd0:    d = 16'd10;
      default: d = 16'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/ttss_cmp_sub.sv =====
// ----------------------------------------------------------------------------
// ttss_cmp_sub
// Shared compare-and-subtract unit used by the divider and the digit split.
// ----------------------------------------------------------------------------
`default_nettype none

module ttss_cmp_sub (
  input  wire logic [ttss_pkg::AluW-1:0] a_i,
  input  wire logic [ttss_pkg::AluW-1:0] b_i,
  output logic      [ttss_pkg::AluW-1:0] diff_o,
  output logic                           ge_o
);
  import ttss_pkg::*;

  logic [AluW:0] wide;

  // A borrow out of the top bit means a is below b.
  assign wide   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = wide[AluW-1:0];
  assign ge_o   = ~wide[AluW];

endmodule

`default_nettype wire

// ===== design/ttss_seq.sv =====
// ----------------------------------------------------------------------------
// ttss_seq
// Step sequencer: idle, division steps, digit steps and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ttss_seq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_div_i,
  input  wire logic                start_dig_i,
  input  wire logic                load_ok_i,
  output ttss_pkg::ttss_ctrl_t     ctrl_o
);
  import ttss_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StDig  = 4'b0100,
    StEmit = 4'b1000
  } ttss_state_e;

  ttss_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      StIdle: begin
        if (start_div_i) begin
          state_d = StDiv;
          cnt_d   = CntW'(DivSteps - 1);
        end else if (start_dig_i) begin
          state_d = StDig;
          cnt_d   = CntW'(DigSteps - 1);
        end
      end
      StDiv: begin
        if (cnt_q == '0) begin
          state_d = StDig;
          cnt_d   = CntW'(DigSteps - 1);
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDig: begin
        if (cnt_q == '0) begin
          state_d = StEmit;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StEmit: begin
        if (load_ok_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign ctrl_o.idle = (state_q == StIdle);
  assign ctrl_o.div  = (state_q == StDiv);
  assign ctrl_o.dig  = (state_q == StDig);
  assign ctrl_o.emit = (state_q == StEmit);
  assign ctrl_o.last = (cnt_q == '0);
  assign ctrl_o.cnt  = cnt_q;

endmodule

`default_nettype wire

// ===== design/tacho_thermo_seven_segment.sv =====
// ----------------------------------------------------------------------------
// tacho_thermo_seven_segment
// Period-averaging tachometer and thermometer with a four-digit display.
// ----------------------------------------------------------------------------
// A temperature word or a period that does not close a block goes through
// the 15 digit steps and hand-off; a period that closes a block goes through
// 32 restoring division steps plus 15 digit steps plus hand-off.
// Throughput: one transaction at a time; the input stalls until the result
// sits in the output register. The shared compare-subtract unit sets the pace.
// Reset clears the period sum and shown value and reloads the sample counter.
`default_nettype none

`include "tacho_thermo_seven_segment_assert.svh"

module tacho_thermo_seven_segment #(
  parameter int unsigned AVG_COUNT = ttss_pkg::AvgCountDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ttss_pkg::ttss_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ttss_pkg::ttss_out_t      out_data_o
);
  import ttss_pkg::*;

  // Dividend of the speed formula; it stays below 2^32 only for block sizes up to 71.
  localparam logic [63:0] RpmNumWide = 64'(RpmScale) * 64'(AVG_COUNT);
  localparam logic [DvdW-1:0] RpmNum = RpmNumWide[DvdW-1:0];

  ttss_ctrl_t ctrl;

  // Control state, initialised by reset.
  logic [SumW-1:0]    sum_q;
  logic [SampleW-1:0] samples_q;
  logic [ValW-1:0]    shown_q;
  logic               out_valid_q;

  // Working registers of the divider and the digit split.
  logic [SumW-1:0] rem_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvdW-1:0] quo_q;
  logic [ValW-1:0] work_q;
  logic [6:0]      thous_q;
  logic [3:0]      hund_q;
  logic [3:0]      tens_q;
  logic            mode_q;
  logic            upd_q;
  ttss_out_t       out_q;

  logic               acc;
  logic               load_ok;
  logic [SumW-1:0]    sum_new;
  logic [SampleW-1:0] samples_dec;
  logic               block_done;
  logic               start_div;
  logic               start_dig;
  logic [18:0]        temp_x5;
  logic [ValW-1:0]    temp_val;
  logic [AluW-1:0]    alu_a;
  logic [AluW-1:0]    alu_b;
  logic [AluW-1:0]    alu_diff;
  logic               alu_ge;
  logic [DvdW-1:0]    quo_full;
  logic [ValW-1:0]    rpm_sat;
  logic [3:0]         thous_idx;

  // A transaction is taken only while the sequencer is idle.
  assign acc        = in_valid_i && ctrl.idle;
  assign in_stall_o = !ctrl.idle;

  // The output register takes a new result when empty or being drained.
  assign load_ok = !out_valid_q || !out_stall_i;

  // Period accumulation happens in the accept cycle.
  assign sum_new     = sum_q + SumW'(in_data_i.period_us);
  assign samples_dec = samples_q - 1'b1;
  assign block_done  = (samples_dec == '0);
  assign start_div   = acc && !in_data_i.mode && block_done;
  assign start_dig   = acc && !start_div;

  // Temperature in tenths: raw * 5 / 8, truncated, since raw counts sixteenths.
  assign temp_x5  = {3'b000, in_data_i.temp_raw} + {1'b0, in_data_i.temp_raw, 2'b00};
  assign temp_val = temp_x5[18:3];

  // The divider shifts one dividend bit into the partial remainder per step;
  // the digit split compares the working value against a scaled weight.
  always_comb begin
    if (ctrl.div) begin
      alu_a = {rem_q, dvd_q[DvdW-1]};
      alu_b = {1'b0, sum_q};
    end else begin
      alu_a = AluW'(work_q);
      alu_b = AluW'(dig_divisor(ctrl.cnt));
    end
  end

  ttss_cmp_sub u_cmp_sub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  ttss_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_div_i (start_div),
    .start_dig_i (start_dig),
    .load_ok_i   (load_ok),
    .ctrl_o      (ctrl)
  );

  // A zero sum makes every step succeed, so the quotient is all ones and
  // saturates to the full-scale value with no special handling.
  assign quo_full = {quo_q[DvdW-2:0], alu_ge};
  assign rpm_sat  = (quo_full[DvdW-1:ValW] != '0) ? '1 : quo_full[ValW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      samples_q   <= SampleW'(AVG_COUNT);
      shown_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc && !in_data_i.mode) begin
        sum_q     <= sum_new;
        samples_q <= block_done ? SampleW'(AVG_COUNT) : samples_dec;
      end else if (ctrl.div && ctrl.last) begin
        sum_q <= '0;
      end
      if (acc && in_data_i.mode) begin
        shown_q <= temp_val;
      end else if (ctrl.div && ctrl.last) begin
        shown_q <= rpm_sat;
      end
      if (ctrl.emit && load_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The thousands place shows digits one to nine, the degree glyph for ten,
  // and stays blank for zero or anything above ten.
  assign thous_idx = ((thous_q == '0) || (thous_q > 7'(GlyphDegree))) ? GlyphBlank
                                                                      : thous_q[3:0];

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mode_q  <= in_data_i.mode;
      rem_q   <= '0;
      dvd_q   <= RpmNum;
      thous_q <= '0;
      hund_q  <= '0;
      tens_q  <= '0;
      upd_q   <= in_data_i.mode || block_done;
      work_q  <= in_data_i.mode ? temp_val : shown_q;
    end else if (ctrl.div) begin
      rem_q <= alu_ge ? alu_diff[SumW-1:0] : alu_a[SumW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
      quo_q <= quo_full;
      if (ctrl.last) begin
        work_q <= rpm_sat;
      end
    end else if (ctrl.dig) begin
      if (alu_ge) begin
        work_q <= alu_diff[ValW-1:0];
      end
      if (ctrl.cnt >= CntW'(8)) begin
        thous_q <= {thous_q[5:0], alu_ge};
      end else if (ctrl.cnt >= CntW'(4)) begin
        hund_q <= {hund_q[2:0], alu_ge};
      end else begin
        tens_q <= {tens_q[2:0], alu_ge};
      end
    end
    if (ctrl.emit && load_ok) begin
      out_q.seg_thousands <= seg_glyph(thous_idx);
      out_q.seg_hundreds  <= seg_glyph(hund_q);
      out_q.seg_tens      <= seg_glyph(tens_q);
      out_q.seg_last      <= seg_glyph(mode_q ? GlyphDegree : GlyphZero);
      out_q.shown_number  <= shown_q;
      out_q.value_updated <= upd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // While dividing, the sample counter has already been reloaded.
  `TTSS_ASSERT_SAME(a_div_reloaded, ctrl.div, samples_q == SampleW'(AVG_COUNT), "counter not reloaded during division")
  // Once the thousands steps are over, the remainder is below one thousand.
  `TTSS_ASSERT_SAME(a_rem_below_k, ctrl.dig && (ctrl.cnt < CntW'(8)), work_q < 16'd1000, "digit remainder out of range")
  // A temperature transaction goes straight to the digit split.
  `TTSS_ASSERT_NEXT(a_temp_to_dig, acc && in_data_i.mode, ctrl.dig, "temperature transaction did not start digit split")

endmodule

`default_nettype wire

// ===== tb/sv/tacho_thermo_seven_segment_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tacho_thermo_seven_segment_tb
// Self-checking testbench for the tachometer and thermometer display block.
// A queue-fed driver sends pulse periods and temperature words. A predictor
// tracks the averaging block and the shown value, and a monitor compares
// every display transaction with it field by field. The sender and the
// receiver each idle at random, in three pressure phases.
// ----------------------------------------------------------------------------
module tacho_thermo_seven_segment_tb;
  import ttss_pkg::*;

  localparam int unsigned AvgCount = AvgCountDefault;
  localparam logic ModePeriod = 1'b0;
  localparam logic ModeTemp   = 1'b1;
  localparam longint unsigned RpmNumerator = 64'd60000000 * AvgCount;
  localparam int unsigned ItemTarget   = 1600;
  localparam int unsigned SettleCycles = 60;

  // Period profiles for the random part. One profile shapes a whole
  // averaging block so that the shown speed lands in a chosen region.
  typedef enum int unsigned {
    ProfZero,     // Every period zero, so the block sum is zero.
    ProfTiny,     // Very short periods, so the speed saturates.
    ProfTenK,     // Speeds around ten thousand rpm.
    ProfSlow,     // Periods near the top of the range, speed near zero.
    ProfWild,     // Fully random periods.
    ProfTypical,  // A steady base period with a little jitter.
    ProfNoise     // A few random transactions that break the block alignment.
  } profile_e;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  ttss_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ttss_out_t out_data;

  ttss_in_t  pending_items[$];
  ttss_out_t display_expected[$];

  int unsigned n_items    = 0;
  int unsigned n_periods  = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;

  // Coverage counters reported in the summary.
  int unsigned temp_words   = 0;
  int unsigned speed_blocks = 0;
  int unsigned zero_blocks  = 0;
  int unsigned sat_blocks   = 0;
  int unsigned degree_leads = 0;

  // Predictor state, reset values as after rst_ni.
  logic [SumW-1:0]    model_sum   = '0;
  logic [SampleW-1:0] model_left  = SampleW'(AvgCount);
  logic [ValW-1:0]    model_shown = '0;

  tacho_thermo_seven_segment #(
    .AVG_COUNT(AvgCount)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #1 clk_i = ~clk_i;

  // The run is split into three pressure phases by the number of accepted
  // transactions: a busy sender with a stalling receiver, the reverse, and then
  // full speed on both sides.
  function automatic int unsigned send_idle_pct();
    if (n_accepted < ItemTarget / 3) return 35;
    if (n_accepted < 2 * ItemTarget / 3) return 79;
    return 0;
  endfunction

  function automatic int unsigned recv_stall_pct();
    if (n_accepted < ItemTarget / 3) return 79;
    if (n_accepted < 2 * ItemTarget / 3) return 35;
    return 0;
  endfunction

  // Lit segments a..g sit at bits 7..1 of the table byte; the display wants
  // them active low at bits 6..0. Indexes past the degree glyph are blank.
  function automatic logic [6:0] glyph_bits(int unsigned idx);
    logic [7:0] lit;
    case (idx)
      0:           lit = 8'hFC;
      1:           lit = 8'h60;
      2:           lit = 8'hDA;
      3:           lit = 8'hF2;
      4:           lit = 8'h66;
      5:           lit = 8'hB6;
      6:           lit = 8'hBE;
      7:           lit = 8'hE0;
      8:           lit = 8'hFE;
      9:           lit = 8'hF6;
      GlyphDegree: lit = 8'hC6;
      default:     lit = 8'h00;
    endcase
    return ~lit[7:1];
  endfunction

  // Advances the predictor by one accepted transaction and returns the
  // display transaction it must produce.
  function automatic ttss_out_t predict_display(ttss_in_t item);
    ttss_out_t res;
    longint unsigned quot;
    int unsigned thou;
    res = '0;
    if (item.mode == ModePeriod) begin
      model_left = model_left - 1'b1;
      model_sum  = model_sum + SumW'(item.period_us);
      if (model_left == '0) begin
        model_left = SampleW'(AvgCount);
        speed_blocks++;
        if (model_sum == '0) begin
          // An all-zero block has no defined speed and shows full scale.
          quot = 65535;
          zero_blocks++;
        end else begin
          quot = RpmNumerator / model_sum;
          if (quot > 65535) begin
            quot = 65535;
            sat_blocks++;
          end
        end
        model_shown = quot[ValW-1:0];
        model_sum   = '0;
        res.value_updated = 1'b1;
      end
    end else begin
      model_shown = ValW'((32'(item.temp_raw) * 5) >> 3);
      res.value_updated = 1'b1;
      temp_words++;
    end
    // A leading zero is blanked; ten shows the degree glyph and anything
    // larger falls on the blank glyph.
    thou = model_shown / 1000;
    if (thou == GlyphDegree) degree_leads++;
    res.seg_thousands = glyph_bits(thou == 0 ? GlyphBlank : thou);
    res.seg_hundreds  = glyph_bits((model_shown % 1000) / 100);
    res.seg_tens      = glyph_bits((model_shown % 100) / 10);
    res.seg_last      = glyph_bits(item.mode == ModeTemp ? GlyphDegree : GlyphZero);
    res.shown_number  = model_shown;
    return res;
  endfunction

  function automatic void push_period(logic [31:0] period);
    ttss_in_t item;
    item.mode      = ModePeriod;
    item.period_us = period;
    item.temp_raw  = 16'($urandom);
    pending_items.push_back(item);
    n_items++;
    n_periods++;
  endfunction

  function automatic void push_temp(logic [15:0] raw);
    ttss_in_t item;
    item.mode      = ModeTemp;
    item.period_us = $urandom;
    item.temp_raw  = raw;
    pending_items.push_back(item);
    n_items++;
  endfunction

  // Temperature words, weighted toward the thousands digit boundaries.
  function automatic logic [15:0] pick_raw();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(17700, 15900));
      2:       return 16'($urandom_range(1700));
      default: return 16'($urandom_range(16000));
    endcase
  endfunction

  function automatic logic [31:0] pick_period(profile_e prof, int unsigned base);
    case (prof)
      ProfZero: return '0;
      ProfTiny: return $urandom_range(900);
      ProfSlow: return $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
      ProfWild: return $urandom;
      default:  return base - base / 16 + $urandom_range(base / 8);
    endcase
  endfunction

  task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
    $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    n_errors++;
  endtask

  // Driver: a transaction is accepted at an edge where valid is high and
  // stall is low. Valid stays up with a steady payload until then.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        display_expected.push_back(predict_display(in_data));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each accepted display transaction is checked against the oldest
  // prediction, and the receiver stall is redrawn every cycle.
  always @(posedge clk_i) begin
    ttss_out_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (display_expected.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %p", $time, out_data);
          n_errors++;
        end else begin
          want = display_expected.pop_front();
          n_checked++;
          if (out_data.seg_thousands !== want.seg_thousands)
            report_mismatch("seg_thousands", want.seg_thousands, out_data.seg_thousands);
          if (out_data.seg_hundreds !== want.seg_hundreds)
            report_mismatch("seg_hundreds", want.seg_hundreds, out_data.seg_hundreds);
          if (out_data.seg_tens !== want.seg_tens)
            report_mismatch("seg_tens", want.seg_tens, out_data.seg_tens);
          if (out_data.seg_last !== want.seg_last)
            report_mismatch("seg_last", want.seg_last, out_data.seg_last);
          if (out_data.shown_number !== want.shown_number)
            report_mismatch("shown_number", want.shown_number, out_data.shown_number);
          if (out_data.value_updated !== want.value_updated)
            report_mismatch("value_updated", want.value_updated, out_data.value_updated);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct());
    end
  end

  initial begin
    profile_e prof;
    int unsigned run_len;
    int unsigned base;

    // Directed part: field extremes and the thousands digit cases. The
    // temperature words land on a blank leading digit, a leading one, the
    // largest four-digit value, ten thousand and up (degree glyph) and
    // eleven thousand (blank again).
    push_temp(16'h0000);
    push_temp(16'hFFFF);
    push_temp(16'd8);
    push_temp(16'd1600);
    push_temp(16'd15999);
    push_temp(16'd16000);
    push_temp(16'd17599);
    push_temp(16'd17600);
    push_temp(16'h5555);
    push_temp(16'hAAAA);
    push_period(32'hFFFF_FFFF);
    push_period(32'h0000_0000);
    push_period(32'h0000_0001);
    push_period(32'h8000_0000);
    push_period(32'h5555_5555);
    push_period(32'hAAAA_AAAA);

    // Random part: mostly whole averaging blocks with one profile each and
    // temperature words mixed in, which must not disturb the running sum.
    while (n_items < ItemTarget) begin
      prof = profile_e'($urandom_range(ProfNoise + 3));
      if (prof > ProfNoise) prof = ProfTypical;
      if (prof == ProfNoise) begin
        repeat ($urandom_range(8, 1)) begin
          if ($urandom_range(1)) push_temp(16'($urandom));
          else push_period($urandom);
        end
      end else begin
        run_len = AvgCount - (n_periods % AvgCount);
        if (prof == ProfTenK) base = $urandom_range(6000, 5460);
        else base = $urandom_range(60000, 600) << $urandom_range(6);
        repeat (run_len) begin
          if ($urandom_range(99) < 15) push_temp(pick_raw());
          push_period(pick_period(prof, base));
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_items) @(posedge clk_i);
    while (display_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Checked %0d of %0d transactions: %0d temperature words, %0d speed readings",
             n_checked, n_accepted, temp_words, speed_blocks);
    $display("(%0d zero-sum, %0d saturated), %0d readings with the degree glyph leading.",
             zero_blocks, sat_blocks, degree_leads);
    if (n_errors == 0 && display_expected.size() == 0) begin
      $display("** tacho_thermo_seven_segment: PASSED **");
    end else begin
      $display("** tacho_thermo_seven_segment: FAILED **");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("%0t ns: timeout with %0d transactions outstanding", $time,
             display_expected.size());
    $display("** tacho_thermo_seven_segment: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/ttss_pkg.sv
design/ttss_cmp_sub.sv
design/ttss_seq.sv
design/tacho_thermo_seven_segment.sv
tb/sv/tacho_thermo_seven_segment_tb.sv
